// ===== design/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg
// Shared types, codes and constants of the directory entry table.
// ----------------------------------------------------------------------------
package det_pkg;

    localparam int unsigned ENTRY_COUNT_DEF  = 32;
    localparam int unsigned NAME_FIELD_BYTES = 16;
    localparam int unsigned NAME_BYTES       = NAME_FIELD_BYTES - 1;
    localparam int unsigned NAME_BITS        = 8 * NAME_BYTES;

    localparam logic [7:0] ATTR_ARCHIVE = 8'h20;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // request as held in the queue, name already normalized
    typedef struct packed {
        t_op         op;
        logic [63:0] name_high;
        logic [55:0] name_low;
        logic [31:0] file_size;
        logic [15:0] start_cluster;
        logic [31:0] timestamp;
    } t_req;

    // one table row as kept in memory
    typedef struct packed {
        logic [63:0] name_high;
        logic [55:0] name_low;
        logic [31:0] file_size;
        logic [15:0] start_cluster;
        logic [31:0] stamp;
    } t_row;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_SCAN  = 2'd2
    } t_state;

    // handshake between front queue and back sequencer
    typedef struct packed {
        logic vld;
    } t_q_stat;

endpackage

// ===== design/det_ram.sv =====
// ----------------------------------------------------------------------------
// det_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module det_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/det_front.sv =====
// ----------------------------------------------------------------------------
// det_front
// Accepts requests, normalizes the name, classifies the request type and
// keeps up to two requests queued for the back end.
// ----------------------------------------------------------------------------
module det_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_req_type,
    input  logic [63:0]     i_name_high,
    input  logic [55:0]     i_name_low,
    input  logic [31:0]     i_file_size,
    input  logic [15:0]     i_start_cluster,
    input  logic [31:0]     i_timestamp,
    input  logic            i_open,
    input  logic            i_pop,
    output det_pkg::t_q_stat o_stat,
    output det_pkg::t_req   o_req
);
    import det_pkg::*;

    logic [NAME_BITS-1:0] w_name_raw;
    logic [NAME_BITS-1:0] w_name_norm;
    t_req                 w_req;
    t_op                  w_op;
    t_req                 r_q [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic                 w_push;

    // every byte after the first zero byte reads as zero
    always_comb begin
        logic live;
        live        = 1'b1;
        w_name_raw  = {i_name_high, i_name_low};
        w_name_norm = '0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (live) begin
                w_name_norm[NAME_BITS-1-8*i -: 8] = w_name_raw[NAME_BITS-1-8*i -: 8];
            end
            if (w_name_raw[NAME_BITS-1-8*i -: 8] == 8'd0) begin
                live = 1'b0;
            end
        end
    end

    always_comb begin
        unique case (i_req_type)
            OP_ADD:    w_op = OP_ADD;
            OP_REMOVE: w_op = OP_REMOVE;
            OP_FIND:   w_op = OP_FIND;
            default:   w_op = OP_NOP;
        endcase
    end

    always_comb begin
        w_req.op            = w_op;
        w_req.name_high     = w_name_norm[NAME_BITS-1 -: 64];
        w_req.name_low      = w_name_norm[55:0];
        w_req.file_size     = i_file_size;
        w_req.start_cluster = i_start_cluster;
        w_req.timestamp     = i_timestamp;
    end

    assign o_in_ready = i_open && (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    assign o_stat.vld  = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("pop from empty queue");

    a_push_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> i_open)
        else $error("transfer taken while table is clearing");

endmodule

// ===== design/det_back.sv =====
// ----------------------------------------------------------------------------
// det_back
// Sequencer that clears the table after reset, scans it one entry per cycle
// for each queued add, remove or find request, applies the update and registers the result.
// ----------------------------------------------------------------------------
module det_back #(
    parameter int unsigned ENTRY_COUNT = det_pkg::ENTRY_COUNT_DEF,
    localparam int unsigned IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  det_pkg::t_q_stat i_stat,
    input  det_pkg::t_req    i_req,
    output logic             o_pop,
    output logic             o_open,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [4:0]       o_entry_index,
    output logic [31:0]      o_found_size,
    output logic [15:0]      o_found_cluster,
    output logic [7:0]       o_found_attributes,
    output logic [31:0]      o_found_created,
    output logic [31:0]      o_found_modified
);
    import det_pkg::*;

    localparam logic [IW-1:0] LAST = IW'(ENTRY_COUNT - 1);

    t_state        r_state;
    t_state        n_state;
    logic [IW-1:0] r_addr;
    logic [IW-1:0] n_addr;
    logic          r_issue_done;
    logic          n_issue_done;
    logic          r_chk_vld;
    logic          n_chk_vld;
    logic [IW-1:0] r_chk_idx;
    logic [IW-1:0] n_chk_idx;

    logic          r_out_vld;
    logic          n_out_vld;
    logic [1:0]    r_status;
    logic [4:0]    r_entry_index;
    logic [31:0]   r_found_size;
    logic [15:0]   r_found_cluster;
    logic [7:0]    r_found_attr;
    logic [31:0]   r_found_time;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_row          w_wdata;
    logic          w_re;
    t_row          w_rdata;

    logic          w_out_free;
    logic          w_occ;
    logic          w_hit;
    logic          w_finish;
    logic          w_load;
    logic [1:0]    w_status;
    logic [4:0]    w_index;
    logic          w_found;

    det_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (ENTRY_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_vld || i_out_ready;

    // add looks for a free row, remove and find for an occupied row with the same name
    assign w_occ = (w_rdata.name_high[63:56] != 8'd0);
    always_comb begin
        if (i_req.op == OP_ADD) begin
            w_hit = !w_occ;
        end else begin
            w_hit = w_occ && (w_rdata.name_high == i_req.name_high)
                          && (w_rdata.name_low == i_req.name_low);
        end
    end

    assign w_finish = (r_state == ST_SCAN) && r_chk_vld && (w_hit || (r_chk_idx == LAST));
    assign w_index  = 5'(32'(r_chk_idx));

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        w_we         = 1'b0;
        w_waddr      = r_chk_idx;
        w_wdata      = '0;
        w_re         = 1'b0;
        o_pop        = 1'b0;
        w_load       = 1'b0;
        w_status     = STAT_MISS;
        w_found      = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_stat.vld) begin
                    if (i_req.op == OP_NOP) begin
                        if (w_out_free) begin
                            w_load = 1'b1;
                            o_pop  = 1'b1;
                        end
                    end else begin
                        n_addr       = '0;
                        n_issue_done = 1'b0;
                        n_chk_vld    = 1'b0;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    if (w_out_free) begin
                        w_load    = 1'b1;
                        o_pop     = 1'b1;
                        n_chk_vld = 1'b0;
                        n_state   = ST_IDLE;
                        if (w_hit) begin
                            w_status = STAT_DONE;
                            w_found  = (i_req.op == OP_FIND);
                            if (i_req.op == OP_ADD) begin
                                w_we                  = 1'b1;
                                w_wdata.name_high     = i_req.name_high;
                                w_wdata.name_low      = i_req.name_low;
                                w_wdata.file_size     = i_req.file_size;
                                w_wdata.start_cluster = i_req.start_cluster;
                                w_wdata.stamp         = i_req.timestamp;
                            end else if (i_req.op == OP_REMOVE) begin
                                w_we = 1'b1;
                            end
                        end else if (i_req.op == OP_ADD) begin
                            w_status = STAT_FULL;
                        end
                    end
                end else begin
                    // one read issued per cycle, compared on the next
                    n_chk_vld = !r_issue_done;
                    if (!r_issue_done) begin
                        w_re      = 1'b1;
                        n_chk_idx = r_addr;
                        if (r_addr == LAST) begin
                            n_issue_done = 1'b1;
                        end else begin
                            n_addr = r_addr + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (w_load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_chk_vld    <= n_chk_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        if (w_load) begin
            r_status        <= w_status;
            r_entry_index   <= (w_status == STAT_DONE) ? w_index : 5'd0;
            r_found_size    <= w_found ? w_rdata.file_size : 32'd0;
            r_found_cluster <= w_found ? w_rdata.start_cluster : 16'd0;
            r_found_attr    <= w_found ? ATTR_ARCHIVE : 8'd0;
            r_found_time    <= w_found ? w_rdata.stamp : 32'd0;
        end
    end

    assign o_open             = (r_state != ST_CLEAR);
    assign o_out_valid        = r_out_vld;
    assign o_status           = r_status;
    assign o_entry_index      = r_entry_index;
    assign o_found_size       = r_found_size;
    assign o_found_cluster    = r_found_cluster;
    assign o_found_attributes = r_found_attr;
    assign o_found_created    = r_found_time;
    assign o_found_modified   = r_found_time;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we)
        else $error("table written while idle");

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (r_state == ST_SCAN))
        else $error("compare pending outside scan");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_vld)
        else $error("request retired without a result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_status != STAT_DONE)) |->
            (r_found_attr == 8'd0 && r_entry_index == 5'd0))
        else $error("failed request carries entry data");

endmodule

// ===== design/directory_entry_table.sv =====
// ----------------------------------------------------------------------------
// directory_entry_table
// Fixed table of file directory entries with add, remove and find by name.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid / o_in_ready with the request type, the
// 15-byte name, size, start cluster and time stamp; each request yields
// exactly one result on o_out_valid / i_out_ready.
// After reset the table is cleared one row per cycle; o_in_ready stays low
// during the clearing pass, and every entry then reads as free.
// A request passes through a two-deep queue to the scan sequencer, which
// reads one table row per cycle from a registered-read RAM and compares it
// on the next cycle. The scan stops at the first matching entry or at the
// last entry, and the result is then registered in the output register.
// An unknown request type is answered from idle without a scan. Add and
// remove write the row back in the same cycle that the result is registered.
// The output register holds a result until it is taken; while it is full
// the sequencer holds at the end of its scan and the queue keeps taking
// requests until it holds two.
// ----------------------------------------------------------------------------
module directory_entry_table #(
    parameter int unsigned ENTRY_COUNT = det_pkg::ENTRY_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_name_high,
    input  logic [55:0] i_name_low,
    input  logic [31:0] i_file_size,
    input  logic [15:0] i_start_cluster,
    input  logic [31:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_index,
    output logic [31:0] o_found_size,
    output logic [15:0] o_found_cluster,
    output logic [7:0]  o_found_attributes,
    output logic [31:0] o_found_created,
    output logic [31:0] o_found_modified
);
    import det_pkg::*;

    t_q_stat w_stat;
    t_req    w_req;
    logic    w_pop;
    logic    w_open;

    det_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_name_high     (i_name_high),
        .i_name_low      (i_name_low),
        .i_file_size     (i_file_size),
        .i_start_cluster (i_start_cluster),
        .i_timestamp     (i_timestamp),
        .i_open          (w_open),
        .i_pop           (w_pop),
        .o_stat          (w_stat),
        .o_req           (w_req)
    );

    det_back #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_stat             (w_stat),
        .i_req              (w_req),
        .o_pop              (w_pop),
        .o_open             (w_open),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_entry_index      (o_entry_index),
        .o_found_size       (o_found_size),
        .o_found_cluster    (o_found_cluster),
        .o_found_attributes (o_found_attributes),
        .o_found_created    (o_found_created),
        .o_found_modified   (o_found_modified)
    );

endmodule

// ===== tb/directory_entry_table_test.sv =====
// ----------------------------------------------------------------------------
// directory_entry_table_test
// Self-checking bench for the directory entry table: directed add, remove and
// find cases, a full-table pass, random traffic under several idle mixes and
// a long output hold-off, all checked against a predictor of the table.
// ----------------------------------------------------------------------------
module directory_entry_table_test;

    import det_pkg::*;

    localparam int ENTRIES      = ENTRY_COUNT_DEF;
    localparam int POOL_SIZE    = 20;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 48;
    // well above hold-off plus clearing pass plus one slow stalled request
    localparam int QUIET_LIMIT  = 3000;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  index;
        logic [31:0] size;
        logic [15:0] cluster;
        logic [7:0]  attr;
        logic [31:0] created;
        logic [31:0] modified;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = OP_NOP;
    logic [63:0] i_name_high = '0;
    logic [55:0] i_name_low = '0;
    logic [31:0] i_file_size = '0;
    logic [15:0] i_start_cluster = '0;
    logic [31:0] i_timestamp = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [4:0]  o_entry_index;
    logic [31:0] o_found_size;
    logic [15:0] o_found_cluster;
    logic [7:0]  o_found_attributes;
    logic [31:0] o_found_created;
    logic [31:0] o_found_modified;

    // predicted table contents
    logic [119:0] dir_name    [ENTRIES];
    logic [31:0]  dir_size    [ENTRIES];
    logic [15:0]  dir_cluster [ENTRIES];
    logic [31:0]  dir_stamp   [ENTRIES];

    logic [119:0] name_pool [POOL_SIZE];
    t_answer      answer_queue [$];
    t_answer      answer_now;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_pending   = 1'b0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;

    directory_entry_table i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_name_high        (i_name_high),
        .i_name_low         (i_name_low),
        .i_file_size        (i_file_size),
        .i_start_cluster    (i_start_cluster),
        .i_timestamp        (i_timestamp),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_entry_index      (o_entry_index),
        .o_found_size       (o_found_size),
        .o_found_cluster    (o_found_cluster),
        .o_found_attributes (o_found_attributes),
        .o_found_created    (o_found_created),
        .o_found_modified   (o_found_modified)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    // applies one request to the predicted table and returns its answer
    function automatic t_answer predict_request(t_op op, logic [119:0] raw,
                                                logic [31:0] size, logic [15:0] cluster,
                                                logic [31:0] stamp);
        t_answer      ans;
        logic [119:0] key;
        bit           ended;
        bit           hit;
        int           b;
        int           k;
        ans = '0;
        ans.status = STAT_MISS;
        key = raw;
        ended = 1'b0;
        hit = 1'b0;
        // the name stops at its first zero byte
        for (b = 0; b < 15; b++) begin
            if (ended) key[119-8*b -: 8] = 8'h00;
            else if (key[119-8*b -: 8] == 8'h00) ended = 1'b1;
        end
        case (op)
            OP_ADD: begin
                ans.status = STAT_FULL;
                for (k = 0; k < ENTRIES; k++) begin
                    if (!hit && dir_name[k][119:112] == 8'h00) begin
                        hit = 1'b1;
                        dir_name[k] = key;
                        dir_size[k] = size;
                        dir_cluster[k] = cluster;
                        dir_stamp[k] = stamp;
                        ans.status = STAT_DONE;
                        ans.index = k[4:0];
                    end
                end
            end
            OP_REMOVE, OP_FIND: begin
                for (k = 0; k < ENTRIES; k++) begin
                    if (!hit && dir_name[k][119:112] != 8'h00 && dir_name[k] == key) begin
                        hit = 1'b1;
                        ans.status = STAT_DONE;
                        ans.index = k[4:0];
                        if (op == OP_REMOVE) begin
                            dir_name[k] = '0;
                            dir_size[k] = '0;
                            dir_cluster[k] = '0;
                            dir_stamp[k] = '0;
                        end else begin
                            ans.size = dir_size[k];
                            ans.cluster = dir_cluster[k];
                            ans.attr = ATTR_ARCHIVE;
                            ans.created = dir_stamp[k];
                            ans.modified = dir_stamp[k];
                        end
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    function automatic logic [119:0] text_name(string s);
        logic [119:0] v;
        int           b;
        v = '0;
        for (b = 0; b < s.len() && b < 15; b++) v[119-8*b -: 8] = s[b];
        return v;
    endfunction

    // random bytes after the terminator, which the block must ignore
    function automatic logic [119:0] with_junk(logic [119:0] name);
        logic [119:0] v;
        bit           ended;
        int           b;
        v = name;
        ended = 1'b0;
        for (b = 0; b < 15; b++) begin
            if (ended) v[119-8*b -: 8] = 8'($urandom_range(0, 255));
            else if (v[119-8*b -: 8] == 8'h00) ended = 1'b1;
        end
        return v;
    endfunction

    function automatic int first_taken();
        int k;
        for (k = 0; k < ENTRIES; k++) begin
            if (dir_name[k][119:112] != 8'h00) return k;
        end
        return -1;
    endfunction

    function automatic int first_free();
        int k;
        for (k = 0; k < ENTRIES; k++) begin
            if (dir_name[k][119:112] == 8'h00) return k;
        end
        return -1;
    endfunction

    task automatic send_request(t_op op, logic [119:0] name, logic [31:0] size,
                                logic [15:0] cluster, logic [31:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= op;
        i_name_high <= name[119:56];
        i_name_low <= name[55:0];
        i_file_size <= size;
        i_start_cluster <= cluster;
        i_timestamp <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        answer_queue.push_back(predict_request(op, name, size, cluster, stamp));
    endtask

    task automatic send_random_item(int add_w);
        t_op          op;
        logic [119:0] name;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 4) op = OP_NOP;
        else if (r < 4 + add_w) op = OP_ADD;
        else if ($urandom_range(0, 1) == 0) op = OP_REMOVE;
        else op = OP_FIND;
        r = $urandom_range(0, 99);
        if (r < 5 && op != OP_ADD) begin
            name = 120'({$urandom, $urandom, $urandom, $urandom});
        end else if (r < 9) begin
            name = 120'({$urandom, $urandom, $urandom, $urandom});
            name[119:112] = 8'h00;
        end else begin
            name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 3) == 0) name = with_junk(name);
        end
        send_request(op, name, $urandom, 16'($urandom), $urandom);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (answer_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic build_name_pool();
        int p;
        int len;
        int b;
        for (p = 0; p < POOL_SIZE; p++) begin
            len = (p == 0) ? 15 : (p == 1) ? 1 : $urandom_range(1, 15);
            name_pool[p] = '0;
            for (b = 0; b < len; b++) name_pool[p][119-8*b -: 8] = 8'($urandom_range(1, 255));
        end
    endtask

    task automatic test_directed_cases();
        logic [119:0] all_ones;
        all_ones = '1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_request(OP_FIND, text_name("README"), 0, 0, 0);
        send_request(OP_REMOVE, text_name("README"), 0, 0, 0);
        send_request(OP_ADD, text_name("README"), 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        send_request(OP_ADD, all_ones, 0, 0, 0);
        send_request(OP_FIND, with_junk(text_name("README")), 0, 0, 0);
        send_request(OP_FIND, all_ones, 0, 0, 0);
        // empty name takes the slot's data but leaves it free
        send_request(OP_ADD, with_junk('0), 32'h1234_5678, 16'h9abc, 32'h0bad_cafe);
        send_request(OP_FIND, '0, 0, 0, 0);
        send_request(OP_REMOVE, with_junk('0), 0, 0, 0);
        send_request(OP_ADD, text_name("AB"), 32'h0000_0001, 16'h0001, 32'h8000_0000);
        send_request(OP_ADD, text_name("README"), 32'h5555_aaaa, 16'haa55, 32'h0f0f_f0f0);
        send_request(OP_REMOVE, text_name("README"), 0, 0, 0);
        send_request(OP_FIND, text_name("README"), 0, 0, 0);
        send_request(OP_ADD, text_name("X"), 32'h0000_0400, 16'h0002, 32'h0000_0003);
        send_request(OP_FIND, with_junk(text_name("AB")), 0, 0, 0);
        send_request(OP_FIND, text_name("ABC"), 0, 0, 0);
        send_request(OP_FIND, text_name("A"), 0, 0, 0);
        send_request(OP_NOP, text_name("AB"), $urandom, 16'($urandom), $urandom);
        send_request(OP_NOP, all_ones, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        send_request(OP_ADD, text_name("FIFTEEN_CHARS_X"), 32'hdead_beef, 16'h7fff,
                     32'h7fff_ffff);
        send_request(OP_FIND, text_name("FIFTEEN_CHARS_X"), 0, 0, 0);
        send_request(OP_REMOVE, all_ones, 0, 0, 0);
        send_request(OP_FIND, all_ones, 0, 0, 0);
        drain();
    endtask

    task automatic test_table_full();
        int n;
        n = 0;
        while (first_free() >= 0) begin
            send_request(OP_ADD, name_pool[n % POOL_SIZE], $urandom, 16'($urandom), $urandom);
            n++;
        end
        send_request(OP_ADD, name_pool[0], $urandom, 16'($urandom), $urandom);
        send_request(OP_ADD, '0, $urandom, 16'($urandom), $urandom);
        send_request(OP_FIND, name_pool[1], 0, 0, 0);
        while (first_taken() >= 0) begin
            send_request(OP_REMOVE, with_junk(dir_name[first_taken()]), 0, 0, 0);
        end
        send_request(OP_REMOVE, name_pool[0], 0, 0, 0);
        drain();
    endtask

    task automatic test_random_traffic(int count, int idle_in, int stall_out);
        int n;
        int add_w;
        send_idle_pct = idle_in;
        recv_stall_pct = stall_out;
        add_w = 62;
        for (n = 0; n < count; n++) begin
            // swing the fill level between full and nearly empty
            if (n % 64 == 0) add_w = ((n / 64) % 2 == 0) ? 62 : 22;
            send_random_item(add_w);
        end
        drain();
    endtask

    task automatic test_output_hold_off();
        int n;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_pending = 1'b1;
        for (n = 0; n < 24; n++) send_random_item(45);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answer_queue.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, '0);
            end else begin
                answer_now = answer_queue.pop_front();
                if (o_status !== answer_now.status)
                    report_mismatch("status", o_status, answer_now.status);
                if (o_entry_index !== answer_now.index)
                    report_mismatch("entry_index", o_entry_index, answer_now.index);
                if (o_found_size !== answer_now.size)
                    report_mismatch("found_size", o_found_size, answer_now.size);
                if (o_found_cluster !== answer_now.cluster)
                    report_mismatch("found_cluster", o_found_cluster, answer_now.cluster);
                if (o_found_attributes !== answer_now.attr)
                    report_mismatch("found_attributes", o_found_attributes, answer_now.attr);
                if (o_found_created !== answer_now.created)
                    report_mismatch("found_created", o_found_created, answer_now.created);
                if (o_found_modified !== answer_now.modified)
                    report_mismatch("found_modified", o_found_modified, answer_now.modified);
            end
        end
    end

    // counts cycles without any transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < ENTRIES; k++) begin
            dir_name[k] = '0;
            dir_size[k] = '0;
            dir_cluster[k] = '0;
            dir_stamp[k] = '0;
        end
        build_name_pool();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_table_full();
        test_random_traffic(420, 0, 0);
        test_random_traffic(420, 71, 0);
        test_random_traffic(420, 0, 71);
        test_random_traffic(420, 25, 25);
        test_output_hold_off();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
